// File: src/ufrc_pkg.sv
// ---------------------------------------------------------------------------
// ufrc_pkg
// Shared types and constants for the disjoint-set engine: table entry,
// memory write request, result word and operation codes.
// ---------------------------------------------------------------------------
package ufrc_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int RANK_W       = 4;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [1:0]        func_t;

	localparam rank_t RANK_MAX   = '1;
	localparam cnt_t  COUNT_FULL = CNT_W'(MAX_ELEMENTS);
	localparam idx_t  IDX_LAST   = IDX_W'(MAX_ELEMENTS - 1);

	localparam func_t FUNC_UNION = 2'd0;
	localparam func_t FUNC_QUERY = 2'd1;
	localparam func_t FUNC_READ  = 2'd2;

	typedef struct packed {
		rank_t rank;
		idx_t  link;
	} entry_t;

	typedef struct packed {
		logic   en;
		idx_t   addr;
		entry_t data;
	} mem_wr_t;

	typedef struct packed {
		logic status;
		logic same_set;
		idx_t value;
	} result_t;

endpackage

// File: src/ufrc_table.sv
// ---------------------------------------------------------------------------
// ufrc_table
// Link/rank table: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ufrc_table (
	input  logic             clk,
	input  ufrc_pkg::mem_wr_t wr,
	input  logic             rd_en,
	input  ufrc_pkg::idx_t   rd_addr,
	output ufrc_pkg::entry_t rd_data
);
	import ufrc_pkg::*;

	entry_t mem_q [MAX_ELEMENTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: src/ufrc_cfg.sv
// ---------------------------------------------------------------------------
// ufrc_cfg
// Element count register and table init sweep. The sweep runs after reset
// and after each count write, one entry per cycle.
// ---------------------------------------------------------------------------
module ufrc_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  ufrc_pkg::cnt_t    cfg_data,
	output ufrc_pkg::cnt_t    count,
	output logic              busy,
	output ufrc_pkg::mem_wr_t wr
);
	import ufrc_pkg::*;

	cnt_t count_q;
	logic busy_q;
	idx_t idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_FULL;
			busy_q  <= 1'b1;
			idx_q   <= '0;
		end else if (cfg_we) begin
			count_q <= (cfg_data > COUNT_FULL) ? COUNT_FULL : cfg_data;
			busy_q  <= 1'b1;
			idx_q   <= '0;
		end else if (busy_q) begin
			idx_q <= idx_q + idx_t'(1);
			if (idx_q == IDX_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign count = count_q;
	assign busy  = busy_q;

	always_comb begin
		wr.en        = busy_q;
		wr.addr      = idx_q;
		wr.data.rank = '0;
		wr.data.link = idx_q;
	end

endmodule

// File: src/ufrc_seq.sv
// ---------------------------------------------------------------------------
// ufrc_seq
// Operation sequencer: root walk, path compression pass and union by rank,
// all driven through one equality comparator and the table's read and write ports.
// ---------------------------------------------------------------------------
module ufrc_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ufrc_pkg::func_t   func,
	input  ufrc_pkg::idx_t    elem_a,
	input  ufrc_pkg::idx_t    elem_b,
	input  ufrc_pkg::cnt_t    count,
	input  logic              busy,
	input  logic              res_ready,
	output logic              res_valid,
	output ufrc_pkg::result_t res,
	output logic              rd_en,
	output ufrc_pkg::idx_t    rd_addr,
	input  ufrc_pkg::entry_t  rd_data,
	output ufrc_pkg::mem_wr_t wr
);
	import ufrc_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_READ = 7'b0000010,
		ST_WALK = 7'b0000100,
		ST_COMP = 7'b0001000,
		ST_JOIN = 7'b0010000,
		ST_BUMP = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t  state_q;
	func_t   func_q;
	idx_t    b_q, x_q, cur_q, root_q, root_a_q, hi_q;
	rank_t   rank_q, rank_a_q, rank_hi_q;
	logic    find_b_q;
	result_t res_q;

	idx_t  cmp_l, cmp_r;
	logic  eq;
	logic  accept, func_ok, invalid;
	logic  a_low, do_link;
	idx_t  hi, lo;
	rank_t rank_hi, rank_lo;

	// shared comparator: walk checks for a self link, compression checks for
	// reaching the root, join checks whether both roots match
	always_comb begin
		case (state_q)
			ST_WALK: begin
				cmp_l = rd_data.link;
				cmp_r = cur_q;
			end
			ST_COMP: begin
				cmp_l = cur_q;
				cmp_r = root_q;
			end
			default: begin
				cmp_l = root_a_q;
				cmp_r = root_q;
			end
		endcase
	end
	assign eq = (cmp_l == cmp_r);

	assign in_ready = (state_q == ST_IDLE) && !busy;
	assign accept   = in_valid && in_ready;
	assign func_ok  = (func == FUNC_UNION) || (func == FUNC_QUERY) || (func == FUNC_READ);
	assign invalid  = !func_ok || ({1'b0, elem_a} >= count) ||
	                  ((func != FUNC_READ) && ({1'b0, elem_b} >= count));

	// union by rank; ties keep the root of the first element
	assign a_low   = (rank_a_q < rank_q);
	assign hi      = a_low ? root_q : root_a_q;
	assign lo      = a_low ? root_a_q : root_q;
	assign rank_hi = a_low ? rank_q : rank_a_q;
	assign rank_lo = a_low ? rank_a_q : rank_q;
	assign do_link = (func_q == FUNC_UNION) && !eq;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q;
		wr      = '0;
		case (state_q)
			ST_IDLE: begin
				rd_en   = accept;
				rd_addr = elem_a;
			end
			ST_WALK: begin
				rd_en   = 1'b1;
				rd_addr = eq ? x_q : rd_data.link;
			end
			ST_COMP: begin
				if (!eq) begin
					wr.en        = 1'b1;
					wr.addr      = cur_q;
					wr.data.rank = rd_data.rank;
					wr.data.link = root_q;
					rd_en        = 1'b1;
					rd_addr      = rd_data.link;
				end else if (!find_b_q) begin
					rd_en   = 1'b1;
					rd_addr = b_q;
				end
			end
			ST_JOIN: begin
				if (do_link) begin
					wr.en        = 1'b1;
					wr.addr      = lo;
					wr.data.rank = rank_lo;
					wr.data.link = hi;
				end
			end
			ST_BUMP: begin
				wr.en        = 1'b1;
				wr.addr      = hi_q;
				wr.data.rank = rank_hi_q + rank_t'(1);
				wr.data.link = hi_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (invalid) begin
							state_q <= ST_DONE;
						end else if (func == FUNC_READ) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_READ: state_q <= ST_DONE;
				ST_WALK: begin
					if (eq) begin
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					if (eq) begin
						state_q <= find_b_q ? ST_JOIN : ST_WALK;
					end
				end
				ST_JOIN: begin
					if (do_link && (rank_a_q == rank_q) && (rank_hi != RANK_MAX)) begin
						state_q <= ST_BUMP;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_BUMP: state_q <= ST_DONE;
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				func_q   <= func;
				b_q      <= elem_b;
				x_q      <= elem_a;
				cur_q    <= elem_a;
				find_b_q <= 1'b0;
				res_q    <= '{status: 1'b1, same_set: 1'b0, value: '0};
			end
			ST_READ: begin
				res_q <= '{status: 1'b0, same_set: 1'b0, value: rd_data.link};
			end
			ST_WALK: begin
				if (eq) begin
					root_q <= cur_q;
					rank_q <= rd_data.rank;
					cur_q  <= x_q;
				end else begin
					cur_q <= rd_data.link;
				end
			end
			ST_COMP: begin
				if (!eq) begin
					cur_q <= rd_data.link;
				end else if (!find_b_q) begin
					root_a_q <= root_q;
					rank_a_q <= rank_q;
					find_b_q <= 1'b1;
					x_q      <= b_q;
					cur_q    <= b_q;
				end
			end
			ST_JOIN: begin
				hi_q      <= hi;
				rank_hi_q <= rank_hi;
				res_q     <= '{status: 1'b0, same_set: eq,
				               value: do_link ? hi : root_a_q};
			end
			default: begin
			end
		endcase
	end

	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

endmodule

// File: src/union_find_rank_compress_unit.sv
// ---------------------------------------------------------------------------
// union_find_rank_compress_unit
// Disjoint-set engine with union by rank and full path compression over a
// 1024-entry link/rank table.
//
//   channel  | handshake           | word
//   ---------+---------------------+---------------------------------
//   input    | in_valid/in_ready   | func, elem_a, elem_b
//   output   | out_valid/out_ready | status, same_set, value
//   config   | cfg_we              | cfg_data (element count)
//
// One word at a time. Invalid words and reads skip the finds; a union or
// query runs two finds, and a union may then grow a rank. Each find is a
// root walk of table reads, then a compression pass that points every
// visited node at the root and ends in one root check. After reset and
// after every count write an init sweep over all 1024 entries runs;
// in_ready stays low meanwhile. The output register lets a new word in
// while the previous result waits; a stalled output holds the sequencer.
// ---------------------------------------------------------------------------
module union_find_rank_compress_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  ufrc_pkg::cnt_t  cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  ufrc_pkg::func_t func,
	input  ufrc_pkg::idx_t  elem_a,
	input  ufrc_pkg::idx_t  elem_b,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            status,
	output logic            same_set,
	output ufrc_pkg::idx_t  value
);
	import ufrc_pkg::*;

	cnt_t    count;
	logic    busy;
	mem_wr_t clr_wr, seq_wr, tbl_wr;
	logic    rd_en;
	idx_t    rd_addr;
	entry_t  rd_data;
	logic    res_valid, res_ready;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	ufrc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.count    (count),
		.busy     (busy),
		.wr       (clr_wr)
	);

	ufrc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.elem_a    (elem_a),
		.elem_b    (elem_b),
		.count     (count),
		.busy      (busy),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr        (seq_wr)
	);

	// init sweep owns write port; user keeps sequencer idle then, unenforced
	assign tbl_wr = clr_wr.en ? clr_wr : seq_wr;

	ufrc_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign same_set  = out_q.same_set;
	assign value     = out_q.value;

endmodule

// File: test/tb_union_find_rank_compress_unit.sv
// ---------------------------------------------------------------------------
// tb_union_find_rank_compress_unit
// Self-checking bench for the disjoint-set engine. A directed table walks
// reads, unions, queries, the unused op code, bad indexes and count writes
// (zero, saturating, small). Random phases follow: each writes a new element
// count, then mixes binomial tree builds (deep link chains) with random
// words. A local copy of the link/rank table predicts every result word.
// Both channels stall at random; two long output hold-offs back the engine up.
// ---------------------------------------------------------------------------
module tb_union_find_rank_compress_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ufrc_pkg::*;

	localparam func_t FUNC_UNUSED   = 2'd3;
	localparam int    LIMIT_CYCLES  = 2_000_000;
	localparam int    LONG_HOLD     = 400;
	localparam int    RANDOM_PHASES = 14;
	localparam int    PHASE_WORDS   = 110;
	localparam int    TAIL_CYCLES   = 60;

	typedef enum logic {ROW_WORD, ROW_COUNT} row_kind_t;

	typedef struct {
		row_kind_t kind;
		func_t     f;
		idx_t      a;
		idx_t      b;
		cnt_t      cnt;
		logic      typed;
		result_t   want;
	} stim_row_t;

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    cfg_we    = 1'b0;
	cnt_t    cfg_data  = '0;
	logic    in_valid  = 1'b0;
	logic    in_ready;
	func_t   func      = FUNC_UNION;
	idx_t    elem_a    = '0;
	idx_t    elem_b    = '0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	logic    status;
	logic    same_set;
	idx_t    value;

	// local copy of the engine's table
	idx_t    dsu_link [MAX_ELEMENTS];
	rank_t   dsu_rank [MAX_ELEMENTS];
	cnt_t    dsu_count;

	result_t pending_results [$];
	int      words_sent  = 0;
	int      words_seen  = 0;
	int      mismatches  = 0;
	int      hold_reqs   = 0;
	logic    tx_steady   = 1'b0;
	logic    rx_steady   = 1'b0;
	int unsigned cycles  = 0;

	union_find_rank_compress_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.elem_a    (elem_a),
		.elem_b    (elem_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.same_set  (same_set),
		.value     (value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("tb_union_find_rank_compress_unit failed");
			$finish;
		end
	end

	function automatic void dsu_clear();
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			dsu_link[i] = idx_t'(i);
			dsu_rank[i] = '0;
		end
	endfunction

	// root walk, then point every visited node straight at the root
	function automatic idx_t resolve_root(idx_t x);
		idx_t root;
		idx_t cur;
		idx_t nxt;
		int   steps;
		root  = x;
		steps = 0;
		while (dsu_link[root] != root && steps < MAX_ELEMENTS) begin
			root = dsu_link[root];
			steps++;
		end
		cur   = x;
		steps = 0;
		while (cur != root && steps < MAX_ELEMENTS) begin
			nxt           = dsu_link[cur];
			dsu_link[cur] = root;
			cur           = nxt;
			steps++;
		end
		return root;
	endfunction

	function automatic result_t dsu_apply(func_t f, idx_t a, idx_t b);
		result_t res;
		idx_t    ra;
		idx_t    rb;
		idx_t    hi;
		idx_t    lo;
		logic    a_ok;
		logic    b_ok;
		res.status   = 1'b1;
		res.same_set = 1'b0;
		res.value    = '0;
		a_ok = cnt_t'(a) < dsu_count;
		b_ok = cnt_t'(b) < dsu_count;
		if (f == FUNC_READ) begin
			if (a_ok) begin
				res.status = 1'b0;
				res.value  = dsu_link[a];
			end
		end else if ((f == FUNC_UNION || f == FUNC_QUERY) && a_ok && b_ok) begin
			ra           = resolve_root(a);
			rb           = resolve_root(b);
			res.status   = 1'b0;
			res.same_set = (ra == rb);
			res.value    = ra;
			if (f == FUNC_UNION && ra != rb) begin
				hi = ra;
				lo = rb;
				if (dsu_rank[ra] < dsu_rank[rb]) begin
					hi = rb;
					lo = ra;
				end
				dsu_link[lo] = hi;
				if (dsu_rank[hi] == dsu_rank[lo] && dsu_rank[hi] != RANK_MAX)
					dsu_rank[hi] = dsu_rank[hi] + 1'b1;
				res.value = hi;
			end
		end
		return res;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	function automatic func_t rand_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return FUNC_UNION;
		else if (r < 75)
			return FUNC_QUERY;
		else if (r < 95)
			return FUNC_READ;
		return FUNC_UNUSED;
	endfunction

	function automatic idx_t rand_elem(int n, int pool);
		if (n < MAX_ELEMENTS && $urandom_range(0, 99) < 8)
			return idx_t'($urandom_range(n, MAX_ELEMENTS - 1));
		return idx_t'($urandom_range(0, pool - 1));
	endfunction

	function automatic stim_row_t word_row(func_t f, idx_t a, idx_t b);
		stim_row_t row;
		row.kind  = ROW_WORD;
		row.f     = f;
		row.a     = a;
		row.b     = b;
		row.cnt   = '0;
		row.typed = 1'b0;
		row.want  = '0;
		return row;
	endfunction

	function automatic stim_row_t known_row(func_t f, idx_t a, idx_t b,
			logic st, logic ss, idx_t val);
		stim_row_t row;
		row                = word_row(f, a, b);
		row.typed          = 1'b1;
		row.want.status    = st;
		row.want.same_set  = ss;
		row.want.value     = val;
		return row;
	endfunction

	function automatic stim_row_t count_row(cnt_t c);
		stim_row_t row;
		row      = word_row(FUNC_UNION, '0, '0);
		row.kind = ROW_COUNT;
		row.cnt  = c;
		return row;
	endfunction

	task automatic send_word(func_t f, idx_t a, idx_t b, logic typed, result_t typed_want);
		int      gap;
		result_t got;
		gap = tx_steady ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		elem_a   <= a;
		elem_b   <= b;
		do @(posedge clk); while (!in_ready);
		got = dsu_apply(f, a, b);
		pending_results.push_back(typed ? typed_want : got);
		words_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (words_seen != words_sent) @(posedge clk);
	endtask

	// only written with the engine idle; table reinit follows in the DUT
	task automatic write_count(cnt_t c);
		drain();
		repeat (4) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= c;
		@(negedge clk);
		cfg_we   <= 1'b0;
		dsu_count = (c > COUNT_FULL) ? COUNT_FULL : c;
		dsu_clear();
	endtask

	task automatic report(string what, int unsigned want, int unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			words_seen++;
			if (pending_results.size() == 0) begin
				report("word with nothing pending, value", 0, value);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report("status", want.status, status);
				if (same_set !== want.same_set)
					report("same_set", want.same_set, same_set);
				if (value !== want.value)
					report("value", want.value, value);
			end
		end
	end

	initial begin : output_side
		int served;
		int gap;
		served = 0;
		forever begin
			@(negedge clk);
			if (hold_reqs > served) begin
				served++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				gap = rx_steady ? 0 : pick_gap();
				if (gap == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
		end
	end

	initial begin : input_side
		stim_row_t dir_tbl [$];
		cnt_t      c;
		int        n;
		int        pool;
		int        target;
		int        r;
		int        k;
		int        size;
		int        base;

		dsu_count = COUNT_FULL;
		dsu_clear();

		dir_tbl.push_back(known_row(FUNC_READ, 0, 0, 1'b0, 1'b0, 0));
		dir_tbl.push_back(known_row(FUNC_READ, IDX_LAST, 0, 1'b0, 1'b0, IDX_LAST));
		dir_tbl.push_back(known_row(FUNC_QUERY, 0, IDX_LAST, 1'b0, 1'b0, 0));
		dir_tbl.push_back(known_row(FUNC_UNION, 0, 1, 1'b0, 1'b0, 0));
		dir_tbl.push_back(known_row(FUNC_READ, 1, 0, 1'b0, 1'b0, 0));
		// same root on union
		dir_tbl.push_back(known_row(FUNC_UNION, 1, 0, 1'b0, 1'b1, 0));
		dir_tbl.push_back(known_row(FUNC_UNION, 2, 3, 1'b0, 1'b0, 2));
		dir_tbl.push_back(word_row(FUNC_UNION, 3, 1));
		dir_tbl.push_back(word_row(FUNC_READ, 0, 0));
		// read must not compress: 1 still links to 0
		dir_tbl.push_back(word_row(FUNC_READ, 1, 0));
		dir_tbl.push_back(word_row(FUNC_QUERY, 1, 3));
		dir_tbl.push_back(word_row(FUNC_READ, 1, 0));
		dir_tbl.push_back(word_row(FUNC_UNION, IDX_LAST, IDX_LAST - idx_t'(1)));
		dir_tbl.push_back(known_row(FUNC_UNUSED, 5, 6, 1'b1, 1'b0, 0));
		dir_tbl.push_back(known_row(FUNC_UNUSED, IDX_LAST, IDX_LAST, 1'b1, 1'b0, 0));
		dir_tbl.push_back(word_row(FUNC_QUERY, IDX_LAST, 0));
		dir_tbl.push_back(word_row(FUNC_UNION, IDX_LAST, 0));
		dir_tbl.push_back(count_row(5));
		dir_tbl.push_back(known_row(FUNC_READ, 5, 0, 1'b1, 1'b0, 0));
		dir_tbl.push_back(known_row(FUNC_UNION, 4, 5, 1'b1, 1'b0, 0));
		dir_tbl.push_back(known_row(FUNC_QUERY, 5, 0, 1'b1, 1'b0, 0));
		dir_tbl.push_back(word_row(FUNC_UNION, 4, 0));
		dir_tbl.push_back(word_row(FUNC_READ, 4, 0));
		// zero count: everything out of range
		dir_tbl.push_back(count_row(0));
		dir_tbl.push_back(known_row(FUNC_READ, 0, 0, 1'b1, 1'b0, 0));
		dir_tbl.push_back(known_row(FUNC_QUERY, 0, 0, 1'b1, 1'b0, 0));
		// oversized count saturates to the full table
		dir_tbl.push_back(count_row('1));
		dir_tbl.push_back(known_row(FUNC_READ, IDX_LAST, 0, 1'b0, 1'b0, IDX_LAST));
		dir_tbl.push_back(known_row(FUNC_UNION, IDX_LAST, IDX_LAST, 1'b0, 1'b1, IDX_LAST));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].kind == ROW_COUNT)
				write_count(dir_tbl[i].cnt);
			else
				send_word(dir_tbl[i].f, dir_tbl[i].a, dir_tbl[i].b,
					dir_tbl[i].typed, dir_tbl[i].want);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: c = 1;
				1: c = 2;
				2: c = COUNT_FULL;
				3: c = '1;
				4: c = 3;
				default: c = ($urandom_range(0, 99) < 70) ? cnt_t'($urandom_range(2, 64))
					: cnt_t'($urandom_range(65, 2047));
			endcase
			write_count(c);
			n = int'(dsu_count);
			r = $urandom_range(0, 2);
			pool = (r == 0) ? n : (r == 1) ? ((n < 8) ? n : 8) : ((n < 32) ? n : 32);
			tx_steady = (ph % 5 == 2);
			rx_steady = (ph % 5 == 4);
			// long output hold-off while words keep coming: fills the engine
			if (ph == 2 || ph == 9)
				hold_reqs++;
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				r = $urandom_range(0, 99);
				if (r < 25 && n >= 2) begin
					// binomial build: equal-rank merges give the deepest chains
					k = 1;
					while (k < 6 && (1 << (k + 1)) <= n)
						k++;
					k    = $urandom_range(1, k);
					size = 1 << k;
					base = $urandom_range(0, n - size);
					for (int s = 1; s < size; s = s * 2) begin
						for (int i = 0; i < size; i += 2 * s) begin
							if ($urandom_range(0, 1))
								send_word(FUNC_UNION, idx_t'(base + i),
									idx_t'(base + i + s), 1'b0, '0);
							else
								send_word(FUNC_UNION, idx_t'(base + i + s),
									idx_t'(base + i), 1'b0, '0);
						end
					end
					repeat (4)
						send_word($urandom_range(0, 1) ? FUNC_QUERY : FUNC_READ,
							idx_t'(base + $urandom_range(0, size - 1)),
							idx_t'(base + $urandom_range(0, size - 1)), 1'b0, '0);
				end else if (r < 29) begin
					drain();
				end else begin
					repeat (8)
						send_word(rand_func(), rand_elem(n, pool), rand_elem(n, pool),
							1'b0, '0);
				end
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_union_find_rank_compress_unit passed");
		else
			$display("tb_union_find_rank_compress_unit failed");
		$finish;
	end

endmodule
